### rtl/core/wheel_scroll_accelerator_macros.svh
// assertion macros shared by the wheel scroll accelerator checkers
`ifndef WHEEL_SCROLL_ACCELERATOR_MACROS_SVH
`define WHEEL_SCROLL_ACCELERATOR_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define WSA_CHK_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define WSA_CHK_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wsa_pkg.sv
// types and constants of the wheel scroll accelerator
`timescale 1ns / 1ps
`default_nettype none

package wsa_pkg;

  typedef logic [28:0] tag_t;
  typedef logic [23:0] sum_t;
  typedef logic [23:0] pos_t;

  typedef struct packed {
    tag_t tag;
    sum_t sum;
  } entry_t;

  // configuration register indexes
  localparam logic [2:0] REG_ACCEL_ENABLE   = 3'd0;
  localparam logic [2:0] REG_ACCEL_STRENGTH = 3'd1;
  localparam logic [2:0] REG_MAX_GAIN       = 3'd2;
  localparam logic [2:0] REG_SPEED_SCALE    = 3'd3;
  localparam logic [2:0] REG_UNIT_SCALE     = 3'd4;

  // register values after reset
  localparam logic        RST_ACCEL_ENABLE   = 1'b1;
  localparam logic [11:0] RST_ACCEL_STRENGTH = 12'd256;
  localparam logic [11:0] RST_MAX_GAIN       = 12'd1024;
  localparam logic [11:0] RST_SPEED_SCALE    = 12'd256;
  localparam logic [15:0] RST_UNIT_SCALE     = 16'd256;

  // gesture and rate constants
  localparam logic [31:0] GAP_MS         = 32'd200;
  localparam logic [28:0] WINDOW_BUCKETS = 29'd10;
  localparam logic [23:0] SUM_MAX        = 24'hFFFFFF;
  localparam logic [11:0] ONE_GAIN       = 12'd256;
  localparam logic [15:0] RATE_MUL       = 16'd100;
  localparam logic [47:0] RATE_KNEE      = 48'd16384;
  localparam logic [26:0] EXCESS_CAP     = 27'h4000000;
  localparam logic [15:0] BIG_STEP       = 16'd256;

  // last direction codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

endpackage

`default_nettype wire

### rtl/core/wsa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module wsa_ram #(
  parameter int WIDTH = 53,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/wheel_scroll_accelerator.sv
// top level of the wheel scroll accelerator
`timescale 1ns / 1ps
`default_nettype none

// Wheel scroll accelerator: takes one scroll event per transaction and returns the
// clamped new position. Events not from the wheel and zero deltas go from S_START
// straight to S_PUT, which puts the result in the output register. A wheel event is
// worked by a small sequencer around one shared 32x16 multiplier: S_MOD to S_MOD5 find
// the bucket-to-slot remainder by reciprocal multiply, S_RD reads the history ram entry
// of that slot and S_UPD writes it back with the step added, S_SUM sweeps the history
// ram for the 80 ms rate sum, and S_G1 to S_FIN do six multiplies plus the add and
// clamp steps, before S_PUT hands the result on like any other event.
// The input stalls while an event is in work; a finished result waits in the output
// register, so the next event can be taken before it is collected. A result still held
// by out_stall when the next one is ready delays that event by the rest of the stall.
module wheel_scroll_accelerator #(
  parameter int HISTORY_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_from_wheel,
  input  wire logic signed [15:0] in_wheel_delta,
  input  wire logic [31:0] in_event_time,
  input  wire logic [23:0] in_current_position,
  input  wire logic [23:0] in_max_position,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_new_position,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int SLOT_W = $clog2(HISTORY_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int TOT_W  = 24 + SLOT_W;
  localparam int ENT_W  = $bits(wsa_pkg::entry_t);
  localparam logic [CNT_W-1:0] NSLOTS = CNT_W'(HISTORY_SLOTS);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_MOD   = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_UPD   = 5'd4;
  localparam logic [4:0] S_SUM   = 5'd5;
  localparam logic [4:0] S_G1    = 5'd6;
  localparam logic [4:0] S_G2    = 5'd7;
  localparam logic [4:0] S_G3    = 5'd8;
  localparam logic [4:0] S_G4    = 5'd9;
  localparam logic [4:0] S_G5    = 5'd10;
  localparam logic [4:0] S_G6    = 5'd11;
  localparam logic [4:0] S_P1    = 5'd12;
  localparam logic [4:0] S_P2    = 5'd13;
  localparam logic [4:0] S_P3    = 5'd14;
  localparam logic [4:0] S_MV    = 5'd15;
  localparam logic [4:0] S_ABS   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;
  localparam logic [4:0] S_PUT   = 5'd18;
  localparam logic [4:0] S_MOD2  = 5'd19;
  localparam logic [4:0] S_MOD3  = 5'd20;
  localparam logic [4:0] S_MOD4  = 5'd21;
  localparam logic [4:0] S_MOD5  = 5'd22;

  logic [4:0] state_r, state_nxt;

  // configuration registers
  logic        accel_enable_r;
  logic [11:0] accel_strength_r;
  logic [11:0] max_gain_r;
  logic [11:0] speed_scale_r;
  logic [15:0] unit_scale_r;

  // latched event
  logic        wheel_r;
  logic [15:0] delta_r;
  logic [31:0] time_r;
  logic [23:0] pos_r;
  logic [23:0] maxp_r;

  // gesture state
  logic [16:0]              frac_r;
  logic [1:0]               last_sign_r;
  logic [31:0]              last_time_r;
  logic                     active_r;
  logic [HISTORY_SLOTS-1:0] valid_r;

  // working registers
  logic             cont_r;
  logic [15:0]      mag_r;
  logic [SLOT_W-1:0] rem_r;
  logic [28:0]      part_r;
  logic [26:0]      quot_r;
  logic [CNT_W-1:0] sweep_r;
  logic [TOT_W-1:0] total_r;
  logic [47:0]      mul_r;
  logic [26:0]      excess_r;
  logic [11:0]      gain_r;
  logic [39:0]      k_r;
  logic [57:0]      acc_r;
  logic             neg_r;
  logic             mpos_r;
  logic [23:0]      res_r;
  logic             out_valid_r;
  logic [23:0]      out_pos_r;

  logic in_accept;
  logic out_free;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_new_position = out_pos_r;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_enable_r   <= wsa_pkg::RST_ACCEL_ENABLE;
      accel_strength_r <= wsa_pkg::RST_ACCEL_STRENGTH;
      max_gain_r       <= wsa_pkg::RST_MAX_GAIN;
      speed_scale_r    <= wsa_pkg::RST_SPEED_SCALE;
      unit_scale_r     <= wsa_pkg::RST_UNIT_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsa_pkg::REG_ACCEL_ENABLE:   accel_enable_r   <= cfg_wdata[0];
        wsa_pkg::REG_ACCEL_STRENGTH: accel_strength_r <= cfg_wdata[11:0];
        wsa_pkg::REG_MAX_GAIN:       max_gain_r       <= cfg_wdata[11:0];
        wsa_pkg::REG_SPEED_SCALE:    speed_scale_r    <= cfg_wdata[11:0];
        wsa_pkg::REG_UNIT_SCALE:     unit_scale_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // bucket number and its slot by reciprocal multiply
  // floor(2^35 / slots) + 1 gives the exact quotient for any 29-bit bucket
  localparam logic [63:0] SLOT_RECIP = ((64'd1 << 35) / 64'(HISTORY_SLOTS)) + 64'd1;
  localparam logic [15:0] RECIP_LO   = SLOT_RECIP[15:0];
  localparam logic [15:0] RECIP_HI   = SLOT_RECIP[31:16];
  localparam logic [15:0] SLOTS_MUL  = 16'(HISTORY_SLOTS);

  logic [28:0] bucket;
  logic [45:0] quot_sum;
  logic [28:0] rem_full;

  assign bucket   = time_r[31:3];
  assign quot_sum = mul_r[45:0] + 46'(part_r);
  assign rem_full = bucket - mul_r[28:0];

  // shared multiplier operand select
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MOD: begin
        mul_a = 32'(bucket);
        mul_b = RECIP_LO;
      end
      S_MOD2: begin
        mul_a = 32'(bucket);
        mul_b = RECIP_HI;
      end
      S_MOD4: begin
        mul_a = 32'(quot_r);
        mul_b = SLOTS_MUL;
      end
      S_G1: begin
        mul_a = 32'(total_r);
        mul_b = wsa_pkg::RATE_MUL;
      end
      S_G3: begin
        mul_a = 32'(excess_r);
        mul_b = 16'(accel_strength_r);
      end
      S_G5: begin
        mul_a = 32'(unit_scale_r);
        mul_b = 16'(speed_scale_r);
      end
      S_G6: begin
        mul_a = mul_r[31:0];
        mul_b = 16'(gain_r);
      end
      S_P1: begin
        mul_a = mul_r[31:0];
        mul_b = mag_r;
      end
      S_P2: begin
        mul_a = 32'(k_r[39:32]);
        mul_b = mag_r;
      end
      default: ;
    endcase
  end

  assign mul_prod = 48'(mul_a) * 48'(mul_b);

  // history ram
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  wsa_pkg::entry_t       rd_entry;
  wsa_pkg::entry_t       wr_entry;

  assign rd_entry = wsa_pkg::entry_t'(ram_rdata);

  wsa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HISTORY_SLOTS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rem_r),
    .wdata (ENT_W'(wr_entry)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // gesture restart check
  logic [32:0] tdiff;
  logic        time_back;
  logic        time_gap;
  logic        reversal;
  logic        restart;
  logic [15:0] mag_in;

  assign tdiff     = {1'b0, time_r} - {1'b0, last_time_r};
  assign time_back = tdiff[32];
  assign time_gap  = !time_back && (tdiff[31:0] >= wsa_pkg::GAP_MS);
  assign reversal  = (last_sign_r == wsa_pkg::DIR_POS && delta_r[15]) ||
                     (last_sign_r == wsa_pkg::DIR_NEG && !delta_r[15]);
  assign restart   = active_r && (time_back || time_gap || reversal);
  assign mag_in    = delta_r[15] ? (~delta_r + 16'd1) : delta_r;

  // bucket update
  logic        hit;
  logic [24:0] sum_add;
  logic [23:0] sum_new;

  assign hit     = valid_r[rem_r] && (rd_entry.tag == bucket);
  assign sum_add = {1'b0, (hit ? rd_entry.sum : 24'd0)} + 25'(mag_r);
  assign sum_new = sum_add[24] ? wsa_pkg::SUM_MAX : sum_add[23:0];
  assign wr_entry.tag = bucket;
  assign wr_entry.sum = sum_new;
  assign ram_we  = (state_r == S_UPD);

  // sweep address and window test
  logic [SLOT_W-1:0] prev_idx;
  logic [29:0]       bdiff;
  logic              in_window;

  assign ram_raddr = (state_r == S_SUM) ?
                     ((sweep_r == NSLOTS) ? '0 : sweep_r[SLOT_W-1:0]) : rem_r;
  assign prev_idx  = SLOT_W'(sweep_r - CNT_W'(1));
  assign bdiff     = {1'b0, bucket} - {1'b0, rd_entry.tag};
  assign in_window = valid_r[prev_idx] && !bdiff[29] &&
                     (bdiff[28:0] < wsa_pkg::WINDOW_BUCKETS);

  // gain and excess rate
  logic [47:0] excess;
  logic [25:0] gain_raw;
  logic        accel_on;
  logic [11:0] gain_sel;

  assign excess   = (mul_r > wsa_pkg::RATE_KNEE) ? mul_r - wsa_pkg::RATE_KNEE : '0;
  assign gain_raw = 26'(wsa_pkg::ONE_GAIN) + 26'(mul_r[38:14]);
  assign accel_on = accel_enable_r && (cont_r || (mag_r > wsa_pkg::BIG_STEP));

  always_comb begin
    priority if (!accel_on) begin
      gain_sel = wsa_pkg::ONE_GAIN;
    end else if (gain_raw > 26'(max_gain_r)) begin
      gain_sel = (max_gain_r < wsa_pkg::ONE_GAIN) ? wsa_pkg::ONE_GAIN : max_gain_r;
    end else begin
      gain_sel = (gain_raw[11:0] < wsa_pkg::ONE_GAIN) ? wsa_pkg::ONE_GAIN :
                 gain_raw[11:0];
    end
  end

  // motion and final clamp
  logic [57:0] frac_sh;
  logic [25:0] whole;
  logic [27:0] target;
  logic [23:0] res_fin;
  logic        frac_clr;
  logic [15:0] frac_mag;

  assign frac_sh  = {{25{frac_r[16]}}, frac_r, 16'b0};
  assign whole    = acc_r[57:32];
  assign target   = neg_r ? (28'(pos_r) - 28'(whole)) : (28'(pos_r) + 28'(whole));
  assign frac_mag = acc_r[31:16];

  always_comb begin
    priority if (target[27]) begin
      res_fin = '0;
    end else if (target[26:0] > 27'(maxp_r)) begin
      res_fin = maxp_r;
    end else begin
      res_fin = target[23:0];
    end
  end

  assign frac_clr = ((res_fin == 24'd0) && neg_r) || ((res_fin == maxp_r) && mpos_r);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_START;
      S_START: begin
        if (!wheel_r || delta_r == 16'd0) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD:   state_nxt = S_MOD2;
      S_MOD2:  state_nxt = S_MOD3;
      S_MOD3:  state_nxt = S_MOD4;
      S_MOD4:  state_nxt = S_MOD5;
      S_MOD5:  state_nxt = S_RD;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = S_SUM;
      S_SUM:   if (sweep_r == NSLOTS) state_nxt = S_G1;
      S_G1:    state_nxt = S_G2;
      S_G2:    state_nxt = S_G3;
      S_G3:    state_nxt = S_G4;
      S_G4:    state_nxt = S_G5;
      S_G5:    state_nxt = S_G6;
      S_G6:    state_nxt = S_P1;
      S_P1:    state_nxt = S_P2;
      S_P2:    state_nxt = S_P3;
      S_P3:    state_nxt = S_MV;
      S_MV:    state_nxt = S_ABS;
      S_ABS:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_PUT;
      S_PUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and gesture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      frac_r      <= '0;
      last_sign_r <= wsa_pkg::DIR_NONE;
      last_time_r <= '0;
      active_r    <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_START && wheel_r && delta_r != 16'd0) begin
        if (restart) begin
          frac_r  <= '0;
          valid_r <= '0;
        end
        active_r    <= 1'b1;
        last_time_r <= time_r;
        last_sign_r <= delta_r[15] ? wsa_pkg::DIR_NEG : wsa_pkg::DIR_POS;
      end
      if (state_r == S_UPD) begin
        valid_r[rem_r] <= 1'b1;
      end
      if (state_r == S_FIN) begin
        frac_r <= frac_clr ? 17'd0 :
                  (neg_r ? (17'd0 - {1'b0, frac_mag}) : {1'b0, frac_mag});
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_r <= mul_prod;
    if (in_accept) begin
      wheel_r <= in_from_wheel;
      delta_r <= in_wheel_delta;
      time_r  <= in_event_time;
      pos_r   <= in_current_position;
      maxp_r  <= in_max_position;
    end
    if (state_r == S_PUT && out_free) begin
      out_pos_r <= res_r;
    end
    unique case (state_r)
      S_START: begin
        cont_r    <= active_r && !restart;
        mag_r     <= mag_in;
        res_r     <= (!wheel_r && maxp_r < pos_r) ? maxp_r : pos_r;
      end
      S_MOD2: part_r <= mul_r[44:16];
      S_MOD3: quot_r <= quot_sum[45:19];
      S_MOD5: rem_r  <= rem_full[SLOT_W-1:0];
      S_UPD: begin
        sweep_r <= '0;
        total_r <= '0;
      end
      S_SUM: begin
        if (sweep_r != '0 && in_window) begin
          total_r <= total_r + TOT_W'(rd_entry.sum);
        end
        sweep_r <= sweep_r + CNT_W'(1);
      end
      S_G2:  excess_r <= (excess > 48'(wsa_pkg::EXCESS_CAP)) ? wsa_pkg::EXCESS_CAP :
                         excess[26:0];
      S_G4:  gain_r <= gain_sel;
      S_P1:  k_r <= mul_r[39:0];
      S_P2:  acc_r <= 58'(mul_r);
      S_P3:  acc_r <= acc_r + (58'(mul_r[23:0]) << 32);
      S_MV:  acc_r <= delta_r[15] ? (frac_sh + acc_r) : (frac_sh - acc_r);
      S_ABS: begin
        neg_r  <= acc_r[57];
        mpos_r <= !acc_r[57] && (acc_r != '0);
        acc_r  <= acc_r[57] ? (58'd0 - acc_r) : acc_r;
      end
      S_FIN: res_r <= res_fin;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/wsa_checker.sv
// port-level checker of the wheel scroll accelerator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "wheel_scroll_accelerator_macros.svh"

module wsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_new_position
);

  // a held result keeps its value
  `WSA_CHK_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_new_position), "stalled result changed")

  // a result only leaves when taken
  `WSA_CHK_IMP(a_out_taken, clk, rst_n, $fell(out_valid), $past(!out_stall), "result dropped while stalled")

  // an accepted transaction keeps the block busy for the next cycle
  `WSA_CHK_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "block ready right after accept")

  // an idle block with no offer stays idle
  `WSA_CHK_NXT(a_idle_stays, clk, rst_n, !in_valid && !in_stall, !in_stall, "block left idle without a transaction")

  // a new result comes only out of work in progress
  `WSA_CHK_IMP(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared while idle")

endmodule

bind wheel_scroll_accelerator wsa_checker u_wsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_new_position (out_new_position)
);

`default_nettype wire

### dv/wsa_position_check.sv
// result predictor and comparator for the wheel scroll accelerator testbench
`timescale 1ns / 1ps

module wsa_position_check
  import wsa_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_from_wheel,
  input  logic signed [15:0] in_wheel_delta,
  input  logic [31:0]        in_event_time,
  input  pos_t               in_current_position,
  input  pos_t               in_max_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pos_t               out_new_position,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 mismatches,
  output int                 pending
);

  localparam longint WORD = 64'sd4294967296;

  // register copies
  logic        accel_on;
  logic [11:0] strength;
  logic [11:0] gain_cap;
  logic [11:0] speed;
  logic [15:0] unit;

  // gesture state
  longint      carry;
  logic [1:0]  last_dir;
  logic [31:0] last_ts;
  logic        active;
  tag_t        tags[SLOTS];
  sum_t        sums[SLOTS];

  pos_t        expected_pos[$];
  pos_t        want_pos;
  int          result_no;

  function automatic void clear_history();
    carry = 0;
    last_dir = DIR_NONE;
    last_ts = '0;
    active = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tags[i] = '0;
      sums[i] = '0;
    end
  endfunction

  // position after one event, advancing the gesture state
  function automatic pos_t next_position(input logic wheel, input logic signed [15:0] dlt,
                                         input logic [31:0] ts, input pos_t cur,
                                         input pos_t maxp);
    longint      d, total, excess, gain, k, m, whole, frac, target, top, cap;
    logic        neg, cont;
    logic [16:0] mag;
    logic [24:0] acc;
    tag_t        bkt;
    int          slot;
    if (!wheel)
      return (cur < maxp) ? cur : maxp;
    if (dlt == 0)
      return cur;
    neg = dlt[15];
    // restart on time going back, a long pause or a direction change
    if (active && (ts < last_ts || ts - last_ts >= GAP_MS ||
                   (neg && last_dir == DIR_POS) || (!neg && last_dir == DIR_NEG)))
      clear_history();
    cont = active;
    active = 1'b1;
    last_ts = ts;
    last_dir = neg ? DIR_NEG : DIR_POS;
    d = dlt;
    mag = 17'(neg ? -d : d);
    // bin into the 8 ms bucket ring
    bkt = ts[31:3];
    slot = int'(bkt % SLOTS);
    if (tags[slot] != bkt) begin
      tags[slot] = bkt;
      sums[slot] = '0;
    end
    acc = {1'b0, sums[slot]} + 25'(mag);
    sums[slot] = (acc > SUM_MAX) ? SUM_MAX : acc[23:0];
    // rate over the last ten buckets
    total = 0;
    for (int i = 0; i < SLOTS; i++)
      if (tags[i] <= bkt && bkt - tags[i] < WINDOW_BUCKETS)
        total += longint'(sums[i]);
    gain = 256;
    if (accel_on && (cont || mag > BIG_STEP)) begin
      excess = total * 100 - 16384;
      if (excess < 0)
        excess = 0;
      gain = 256 + (longint'(strength) * excess) / 16384;
      cap = longint'(gain_cap);
      if (gain > cap)
        gain = cap;
      if (gain < 256)
        gain = 256;
    end
    // exact motion with signed sub-unit carry
    k = longint'(unit) * longint'(speed) * gain;
    m = carry * 65536 - d * k;
    whole = m / WORD;
    frac = m - whole * WORD;
    carry = frac / 65536;
    top = longint'(maxp);
    target = longint'(cur) + whole;
    if (target < 0)
      target = 0;
    if (target > top)
      target = top;
    if ((target == 0 && m < 0) || (target == top && m > 0))
      carry = 0;
    return pos_t'(target);
  endfunction

  task automatic report_mismatch(input string what, input pos_t got, input pos_t want);
    mismatches++;
    if (mismatches <= 40)
      $display("%m: %s at result %0d: got %0d, want %0d", what, result_no, got, want);
  endtask

  // follow the three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      accel_on = RST_ACCEL_ENABLE;
      strength = RST_ACCEL_STRENGTH;
      gain_cap = RST_MAX_GAIN;
      speed = RST_SPEED_SCALE;
      unit = RST_UNIT_SCALE;
      clear_history();
      expected_pos.delete();
      mismatches = 0;
      result_no = 0;
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_ENABLE:   accel_on = cfg_wdata[0];
          REG_ACCEL_STRENGTH: strength = cfg_wdata[11:0];
          REG_MAX_GAIN:       gain_cap = cfg_wdata[11:0];
          REG_SPEED_SCALE:    speed = cfg_wdata[11:0];
          REG_UNIT_SCALE:     unit = cfg_wdata;
          default: ;
        endcase
      end
      // event transaction
      if (in_valid && !in_stall)
        expected_pos.push_back(next_position(in_from_wheel, in_wheel_delta, in_event_time,
                                             in_current_position, in_max_position));
      // result transaction
      if (out_valid && !out_stall) begin
        if (expected_pos.size() == 0) begin
          report_mismatch("result with no event waiting", out_new_position, '0);
        end else begin
          want_pos = expected_pos.pop_front();
          if (out_new_position !== want_pos)
            report_mismatch("new_position mismatch", out_new_position, want_pos);
        end
        result_no++;
      end
    end
    pending = expected_pos.size();
  end

endmodule

### dv/tb_top.sv
// testbench top of the wheel scroll accelerator: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_top;
  import wsa_pkg::*;

  localparam int SLOTS = 16;
  localparam int LIMIT = 2000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_from_wheel = 1'b0;
  logic signed [15:0] in_wheel_delta = '0;
  logic [31:0]        in_event_time = '0;
  pos_t               in_current_position = '0;
  pos_t               in_max_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pos_t               out_new_position;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  int                 mismatches;
  int                 pending;
  int                 stall_left = 0;
  int                 cycle_count = 0;
  bit                 in_calm = 1'b0;
  bit                 out_calm = 1'b0;
  logic [31:0]        stamp = '0;

  always #10 clk = ~clk;

  wheel_scroll_accelerator #(.HISTORY_SLOTS(SLOTS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_from_wheel       (in_from_wheel),
    .in_wheel_delta      (in_wheel_delta),
    .in_event_time       (in_event_time),
    .in_current_position (in_current_position),
    .in_max_position     (in_max_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_position    (out_new_position),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  wsa_position_check #(.SLOTS(SLOTS)) position_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_from_wheel       (in_from_wheel),
    .in_wheel_delta      (in_wheel_delta),
    .in_event_time       (in_event_time),
    .in_current_position (in_current_position),
    .in_max_position     (in_max_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_position    (out_new_position),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .mismatches          (mismatches),
    .pending             (pending)
  );

  // mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    if (r < 95)
      return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [15:0] pick_delta(input logic neg);
    int r, m;
    r = $urandom_range(0, 99);
    if (r < 35)
      m = $urandom_range(1, 64);
    else if (r < 65)
      m = $urandom_range(65, 256);
    else if (r < 85)
      m = $urandom_range(257, 4095);
    else if (r < 95)
      m = $urandom_range(4096, 32767);
    else
      m = neg ? 32768 : 32767;
    return 16'(neg ? -m : m);
  endfunction

  task automatic pick_span(output pos_t cur, output pos_t mx);
    int r;
    r = $urandom_range(0, 9);
    mx = 24'($urandom);
    cur = 24'($urandom);
    case (r)
      0: mx = '0;
      1: mx = '1;
      2: cur = mx;
      3: cur = '0;
      4: ;
      default: cur = 24'($urandom_range(0, mx));
    endcase
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!out_calm && $urandom_range(0, 99) < 30)
        stall_left = gap_len();
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // one event transaction, with an optional idle gap ahead of it
  task automatic put_event(input logic wh, input logic signed [15:0] dl,
                           input logic [31:0] ts, input pos_t cur, input pos_t mx);
    int gap;
    if (!in_calm && $urandom_range(0, 99) < 35) begin
      gap = gap_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_from_wheel <= wh;
    in_wheel_delta <= dl;
    in_event_time <= ts;
    in_current_position <= cur;
    in_max_position <= mx;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // waits for idle, then writes every register plus one unused index
  task automatic load_config(input logic en, input logic [11:0] st, input logic [11:0] cap,
                             input logic [11:0] sp, input logic [15:0] us);
    logic [2:0]  idx[6];
    logic [15:0] dat[6];
    idx[0] = REG_UNIT_SCALE + 3'($urandom_range(1, 3));
    dat[0] = 16'($urandom);
    idx[1] = REG_ACCEL_ENABLE;
    dat[1] = {15'($urandom), en};
    idx[2] = REG_ACCEL_STRENGTH;
    dat[2] = {4'($urandom), st};
    idx[3] = REG_MAX_GAIN;
    dat[3] = {4'($urandom), cap};
    idx[4] = REG_SPEED_SCALE;
    dat[4] = {4'($urandom), sp};
    idx[5] = REG_UNIT_SCALE;
    dat[5] = us;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= dat[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [11:0] cap, sp;
    logic [15:0] us;
    cap = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 255))
                                       : 12'($urandom_range(256, 4095));
    sp = ($urandom_range(0, 9) < 6) ? 12'($urandom_range(64, 512)) : 12'($urandom);
    us = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(16, 768)) : 16'($urandom);
    load_config(1'($urandom), 12'($urandom), cap, sp, us);
  endtask

  // one scroll gesture, mostly well formed with some broken events mixed in
  task automatic run_gesture(inout int counted);
    int   len, r, noise;
    logic neg;
    pos_t cur, mx;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 15);
    neg = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60)
      stamp += $urandom_range(200, 5000);
    else if (r < 80)
      stamp = $urandom;
    else
      stamp += $urandom_range(0, 199);
    for (int i = 0; i < len; i++) begin
      noise = $urandom_range(0, 99);
      pick_span(cur, mx);
      if (noise < 5) begin
        put_event(1'b0, 16'($urandom), $urandom, cur, mx);
      end else if (noise < 8) begin
        put_event(1'b1, '0, stamp, cur, mx);
      end else begin
        if (noise < 11)
          neg = ~neg;
        else if (noise < 13)
          stamp -= $urandom_range(1, 300);
        else if (noise < 15)
          stamp += $urandom_range(200, 1000);
        else begin
          r = $urandom_range(0, 99);
          if (r < 20)
            stamp += 0;
          else if (r < 85)
            stamp += $urandom_range(1, 12);
          else
            stamp += $urandom_range(13, 199);
        end
        put_event(1'b1, pick_delta(neg), stamp, cur, mx);
        counted++;
      end
    end
  endtask

  task automatic run_phase(input int target);
    int counted;
    counted = 0;
    in_calm = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    while (counted < target)
      run_gesture(counted);
    in_valid <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    pos_t cur, mx;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed events under the reset register values
    put_event(1'b0, 16'sh1234, 32'd5, 24'hFFFFFF, 24'h000100);
    put_event(1'b0, 16'sh8000, 32'hFFFFFFFF, 24'd10, 24'hFFFFFF);
    put_event(1'b1, 16'sh0000, 32'd7, 24'hFFFFFF, 24'd5);
    for (int i = 0; i < 4; i++)
      put_event(1'b1, 16'sd1, 32'(i), 24'd1000, 24'd2000);
    put_event(1'b1, 16'sh7FFF, 32'd4, 24'd0, 24'hFFFFFF);
    // reversal with a full negative step, clamped at the top
    put_event(1'b1, 16'sh8000, 32'd5, 24'hFFFFFF, 24'hFFFFFF);
    // time going back, then a gap of exactly 200 ms, then 199 ms
    put_event(1'b1, -16'sd100, 32'd2, 24'd500, 24'd1000);
    put_event(1'b1, -16'sd5, 32'd202, 24'd500, 24'd1000);
    put_event(1'b1, -16'sd5, 32'd401, 24'd500, 24'd1000);
    // bottom edge and a zero-size range
    put_event(1'b1, 16'sd300, 32'd402, 24'd0, 24'd50);
    put_event(1'b1, 16'sd77, 32'd403, 24'd0, 24'd0);
    // timestamps at the top of the range, then wrapping to zero
    put_event(1'b1, 16'sd1, 32'hFFFFFFF0, 24'd3000, 24'd9000);
    put_event(1'b1, 16'sd200, 32'hFFFFFFFF, 24'd3000, 24'd9000);
    put_event(1'b1, 16'sd3, 32'd0, 24'd3000, 24'd9000);
    put_event(1'b0, 16'sh7FFF, 32'hAAAAAAAA, 24'h555555, 24'hAAAAAA);
    put_event(1'b1, -16'sd1, 32'h55555555, 24'hAAAAAA, 24'h555555);
    for (int i = 0; i < 3; i++)
      put_event(1'b1, -16'sd9000, 32'h55555556, 24'h400000, 24'hFFFFFF);
    in_valid <= 1'b0;

    // register extremes
    load_config(1'b0, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF);
    run_phase(120);
    load_config(1'b1, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF);
    run_phase(120);
    load_config(1'b1, 12'd0, 12'd0, 12'd0, 16'd0);
    run_phase(100);
    load_config(1'b1, 12'd2048, 12'd100, 12'd256, 16'd256);
    run_phase(120);

    // long burst in one bucket drives the bucket sum into saturation
    load_config(1'b1, 12'd256, 12'd1024, 12'd256, 16'd256);
    in_calm = 1'b0;
    out_calm = 1'b0;
    stamp += 32'd1000;
    for (int i = 0; i < 520; i++) begin
      pick_span(cur, mx);
      put_event(1'b1, 16'sh8000, stamp, cur, mx);
    end
    in_valid <= 1'b0;

    repeat (7) begin
      random_config();
      run_phase(100);
    end

    // drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
